### hdl/pmid_pkg.sv
// Shared constants and widths for the periodic minimum image distance core.
// No dependencies.
`default_nettype none

package pmid_pkg;

    localparam int NUM_AXES_DEF = 3;
    localparam int AXIS_MAX     = 3;

    localparam int COORD_W    = 32;
    localparam int BOX_W      = 31;
    localparam int MAG_W      = 32;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_W     = 34;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 1;
    localparam int DIST_W     = 33;
    localparam int MASK_W     = 3;

    localparam int MOD_STEPS  = MAG_W;
    localparam int SQRT_STEPS = ROOT_W;
    // mag, mod steps, fold, square, sum, root steps
    localparam int LANE_LAT   = MOD_STEPS + 3;
    localparam int PIPE_LEN   = LANE_LAT + 1 + SQRT_STEPS;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = BOX_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK  = 2'd3;

    localparam logic [BOX_W-1:0]  BOX_RESET  = 31'd65536;
    localparam logic [MASK_W-1:0] MASK_RESET = 3'd7;

endpackage

`default_nettype wire

### hdl/pmid_mod_cell.sv
// One restoring step of the box-length remainder: subtracts box << SHIFT when it fits.
// Depends on pmid_pkg.
`default_nettype none

module pmid_mod_cell #(
    parameter int SHIFT = 0
) (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic                      per_in,
    input  wire logic [pmid_pkg::MAG_W-1:0] rem_in,
    input  wire logic [pmid_pkg::BOX_W-1:0] box,
    output logic                           per_reg,
    output logic [pmid_pkg::MAG_W-1:0]     rem_reg
);
    import pmid_pkg::*;

    localparam int CW = MAG_W + BOX_W;

    logic [CW-1:0]    bshift;
    logic             fits;
    logic [MAG_W-1:0] rem_next;

    always_comb
    begin
        bshift   = {{MAG_W{1'b0}}, box} << SHIFT;
        fits     = per_in && ({{BOX_W{1'b0}}, rem_in} >= bshift);
        rem_next = fits ? (rem_in - bshift[MAG_W-1:0]) : rem_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            per_reg <= per_in;
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

### hdl/pmid_sqrt_cell.sv
// One digit-pair step of the truncated integer square root.
// Depends on pmid_pkg.
`default_nettype none

module pmid_sqrt_cell #(
    parameter int POS = 0
) (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [pmid_pkg::RAD_W-1:0]  rad_in,
    input  wire logic [pmid_pkg::REM_W-1:0]  rem_in,
    input  wire logic [pmid_pkg::ROOT_W-1:0] root_in,
    output logic [pmid_pkg::RAD_W-1:0]      rad_reg,
    output logic [pmid_pkg::REM_W-1:0]      rem_reg,
    output logic [pmid_pkg::ROOT_W-1:0]     root_reg
);
    import pmid_pkg::*;

    localparam int CW = REM_W + 2;

    logic [CW-1:0]     cur;
    logic [CW-1:0]     trial;
    logic              ge;
    logic [CW-1:0]     diff;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    always_comb
    begin
        cur       = {rem_in, rad_in[2*POS+1 -: 2]};
        trial     = {1'b0, root_in, 2'b01};
        ge        = cur >= trial;
        diff      = ge ? (cur - trial) : cur;
        rem_next  = diff[REM_W-1:0];
        root_next = {root_in[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_in;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

endmodule

`default_nettype wire

### hdl/pmid_axis.sv
// One axis lane: difference magnitude, remainder by box length, fold to the
// nearest image, and square. Depends on pmid_pkg and pmid_mod_cell.
`default_nettype none

module pmid_axis (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [pmid_pkg::COORD_W-1:0] first,
    input  wire logic [pmid_pkg::COORD_W-1:0] second,
    input  wire logic [pmid_pkg::BOX_W-1:0]   box,
    input  wire logic                         periodic,
    output logic [pmid_pkg::SQ_W-1:0]         sq_reg
);
    import pmid_pkg::*;

    logic [COORD_W:0]  diff;
    logic [MAG_W-1:0]  mag_next;
    logic              per_next;
    logic [MAG_W-1:0]  rem_reg [MOD_STEPS+1];
    logic              per_reg [MOD_STEPS+1];
    logic [MAG_W-1:0]  fold_next;
    logic [MAG_W-1:0]  fold_reg;
    logic [MAG_W-1:0]  r_last;

    always_comb
    begin
        diff     = {first[COORD_W-1], first} - {second[COORD_W-1], second};
        mag_next = diff[COORD_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
        per_next = periodic && (box != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= mag_next;
            per_reg[0] <= per_next;
        end
    end

    for (genvar k = 0; k < MOD_STEPS; k++)
    begin : g_mod
        pmid_mod_cell #(.SHIFT(MOD_STEPS - 1 - k)) u_cell (
            .clk    (clk),
            .en     (en),
            .per_in (per_reg[k]),
            .rem_in (rem_reg[k]),
            .box    (box),
            .per_reg(per_reg[k+1]),
            .rem_reg(rem_reg[k+1])
        );
    end

    // round half away from zero: remainder at or past half a box folds back
    always_comb
    begin
        r_last = rem_reg[MOD_STEPS];
        if (per_reg[MOD_STEPS] && ({r_last, 1'b0} >= {2'b0, box}))
            fold_next = {1'b0, box} - r_last;
        else
            fold_next = r_last;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fold_reg <= fold_next;
            sq_reg   <= SQ_W'(fold_reg) * SQ_W'(fold_reg);
        end
    end

endmodule

`default_nettype wire

### hdl/periodic_min_image_distance_core.sv
// Minimum image distance between two 3D points in a periodic box.
// Channels: input beat carries first_* / second_* (signed Q16.16), output beat
// carries distance (unsigned Q17.16, truncated square root). Both use
// valid/ready. Config: cfg_we writes cfg_data into register cfg_index
// (0..2 box length x/y/z, 3 periodic mask) at that clock edge.
// The beat is loaded into the magnitude register at the accepting edge, then
// 32 remainder cells, fold, square, sum, 34 root cells and the output reg.
// Throughput: one beat per cycle while in_ready is high; every stage is a register in a fixed chain.
// Stall: an output register plus one skid entry; when the receiver holds off
// with both full, in_ready drops and the whole chain freezes until the skid
// entry drains. in_ready depends on registers only.
// Reset: clears valid bits, boxes go to 1.0, all axes periodic.
// Parameter NUM_AXES: only the first NUM_AXES axes (x, y, z) contribute.
// Depends on pmid_pkg, pmid_axis, pmid_sqrt_cell.
`default_nettype none

module periodic_min_image_distance_core #(
    parameter int NUM_AXES = pmid_pkg::NUM_AXES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [pmid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pmid_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [pmid_pkg::COORD_W-1:0]    first_x,
    input  wire logic [pmid_pkg::COORD_W-1:0]    first_y,
    input  wire logic [pmid_pkg::COORD_W-1:0]    first_z,
    input  wire logic [pmid_pkg::COORD_W-1:0]    second_x,
    input  wire logic [pmid_pkg::COORD_W-1:0]    second_y,
    input  wire logic [pmid_pkg::COORD_W-1:0]    second_z,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [pmid_pkg::DIST_W-1:0]          distance
);
    import pmid_pkg::*;

    logic [BOX_W-1:0]  box_x_reg, box_y_reg, box_z_reg;
    logic [MASK_W-1:0] mask_reg;

    logic              en;
    logic [PIPE_LEN-1:0] vld_reg;

    logic [COORD_W-1:0] fa [AXIS_MAX];
    logic [COORD_W-1:0] sa [AXIS_MAX];
    logic [BOX_W-1:0]   ba [AXIS_MAX];
    logic [SQ_W-1:0]    sq [AXIS_MAX];
    logic [SUM_W-1:0]   sum_reg;

    logic [RAD_W-1:0]  rad  [SQRT_STEPS+1];
    logic [REM_W-1:0]  srem [SQRT_STEPS+1];
    logic [ROOT_W-1:0] root [SQRT_STEPS+1];

    logic              out_valid_reg, skid_valid_reg;
    logic [DIST_W-1:0] out_data_reg, skid_data_reg;
    logic              tail_valid;
    logic [DIST_W-1:0] tail_data;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg <= BOX_RESET;
            box_y_reg <= BOX_RESET;
            box_z_reg <= BOX_RESET;
            mask_reg  <= MASK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BOX_X: box_x_reg <= cfg_data;
                CFG_BOX_Y: box_y_reg <= cfg_data;
                CFG_BOX_Z: box_z_reg <= cfg_data;
                CFG_MASK:  mask_reg  <= cfg_data[MASK_W-1:0];
                default:   ;
            endcase
        end
    end

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_LEN-2:0], in_valid};
    end

    assign fa[0] = first_x;
    assign fa[1] = first_y;
    assign fa[2] = first_z;
    assign sa[0] = second_x;
    assign sa[1] = second_y;
    assign sa[2] = second_z;
    assign ba[0] = box_x_reg;
    assign ba[1] = box_y_reg;
    assign ba[2] = box_z_reg;

    for (genvar a = 0; a < AXIS_MAX; a++)
    begin : g_lane
        if (a < NUM_AXES)
        begin : g_on
            pmid_axis u_axis (
                .clk     (clk),
                .en      (en),
                .first   (fa[a]),
                .second  (sa[a]),
                .box     (ba[a]),
                .periodic(mask_reg[a]),
                .sq_reg  (sq[a])
            );
        end
        else
        begin : g_off
            assign sq[a] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sum_reg <= {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
    end

    assign rad[0]  = {{(RAD_W-SUM_W){1'b0}}, sum_reg};
    assign srem[0] = '0;
    assign root[0] = '0;

    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_sqrt
        pmid_sqrt_cell #(.POS(SQRT_STEPS - 1 - s)) u_cell (
            .clk     (clk),
            .en      (en),
            .rad_in  (rad[s]),
            .rem_in  (srem[s]),
            .root_in (root[s]),
            .rad_reg (rad[s+1]),
            .rem_reg (srem[s+1]),
            .root_reg(root[s+1])
        );
    end

    assign tail_valid = vld_reg[PIPE_LEN-1];
    assign tail_data  = root[SQRT_STEPS][DIST_W-1:0];

    // output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (tail_valid)
        begin
            if (out_valid_reg && !out_ready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
                out_data_reg <= skid_data_reg;
        end
        else if (tail_valid)
        begin
            if (out_valid_reg && !out_ready)
                skid_data_reg <= tail_data;
            else
                out_data_reg <= tail_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = out_data_reg;

endmodule

`default_nettype wire

### hdl/pmid_checker.sv
// Port-level checks for periodic_min_image_distance_core, bound to the top level.
// Depends on pmid_pkg.
`default_nettype none

module pmid_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [pmid_pkg::DIST_W-1:0] distance
);
    import pmid_pkg::*;

    // a held output beat keeps its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance))
        else $error("output beat dropped or changed while stalled");

    // input side only backs off when the output register is full
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low with empty output");

    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("in_ready dropped without an output stall");

    // a taken beat with a stalled skid drains before input resumes
    a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> $past(out_ready))
        else $error("in_ready rose without an output beat taken");

endmodule

bind periodic_min_image_distance_core pmid_checker u_pmid_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .distance (distance)
);

`default_nettype wire

### sim/tb_top.sv
// Self-checking bench for periodic_min_image_distance_core: directed table, then random pairs.
// Depends on pmid_pkg and the core RTL.
`default_nettype none

module tb_top;
    import pmid_pkg::*;

    typedef struct packed {
        logic [31:0] ax, ay, az, bx, by, bz;
    } pair_t;

    typedef struct {
        pair_t       p;
        logic        known;
        logic [32:0] want_dist;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BOX_X;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [31:0] first_x = '0, first_y = '0, first_z = '0;
    logic [31:0] second_x = '0, second_y = '0, second_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [32:0] distance;

    periodic_min_image_distance_core uut (.*);

    always #2 clk = ~clk;

    logic [30:0] box_x, box_y, box_z;
    logic [2:0]  wrap_mask;
    logic [32:0] dist_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_seen = 0;
    longint cycles = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    int hold_cnt = 0;

    function automatic logic [31:0] fold_axis(logic [31:0] a, logic [31:0] b,
                                              logic [30:0] box, logic wrap);
        logic signed [33:0] d;
        logic [33:0] mag, n, sub;
        d = $signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b});
        mag = d[33] ? -d : d;
        if (wrap && box != 0)
        begin
            n = (2 * mag + {3'b0, box}) / (2 * {3'b0, box});
            sub = n * box;
            mag = (sub > mag) ? sub - mag : mag - sub;
        end
        return mag[31:0];
    endfunction

    function automatic logic [32:0] image_distance(pair_t p);
        logic [67:0] s, rem;
        logic [33:0] root;
        logic [31:0] m;
        logic [67:0] trial;
        m = fold_axis(p.ax, p.bx, box_x, wrap_mask[0]);
        s = 68'(m) * 68'(m);
        m = fold_axis(p.ay, p.by, box_y, wrap_mask[1]);
        s += 68'(m) * 68'(m);
        m = fold_axis(p.az, p.bz, box_z, wrap_mask[2]);
        s += 68'(m) * 68'(m);
        root = 0;
        rem = 0;
        for (int i = 33; i >= 0; i--)
        begin
            rem = (rem << 2) | 68'(s[2*i +: 2]);
            trial = {32'b0, root, 2'b01};
            if (rem >= trial)
            begin
                rem -= trial;
                root = (root << 1) | 1;
            end
            else
                root = root << 1;
        end
        return root[32:0];
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BOX_X: box_x = val;
            CFG_BOX_Y: box_y = val;
            CFG_BOX_Z: box_z = val;
            default:   wrap_mask = val[2:0];
        endcase
    endtask

    task automatic drain();
        while (dist_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // one beat; valid may stay high into the next beat
    task automatic send(pair_t p, logic known, logic [32:0] want_dist, bit keep);
        logic [32:0] want;
        want = known ? want_dist : image_distance(p);
        in_valid <= 1'b1;
        {first_x, first_y, first_z, second_x, second_y, second_z} <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        dist_q.insert(dist_q.size(), want);
        n_sent++;
        if (!keep)
            in_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rnd_box();
        case ($urandom_range(0, 4))
            0: return 31'd1;
            1: return 31'h7fff_ffff;
            2: return 31'($urandom_range(1, 32'h0010_0000));
            3: return 31'd0;
            default: return 31'($urandom);
        endcase
    endfunction

    // receiver: random stalls, one long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_cnt <= 400;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 3) != 0) || (cycles[9:7] == 3'd5);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("timeout at %0t", $time);
            $display("FAIL");
            $finish;
        end
        if (out_valid && out_ready)
        begin
            n_seen++;
            if (dist_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected distance %h", $time, distance);
            end
            else
            begin
                logic [32:0] w;
                w = dist_q.pop_front();
                if (w !== distance)
                begin
                    errors++;
                    $display("%0t: distance expected %h actual %h", $time, w, distance);
                end
            end
        end
    end

    row_t rows[$];

    initial
    begin
        pair_t p;
        logic [32:0] zero;
        int burst;
        zero = '0;
        box_x = BOX_RESET; box_y = BOX_RESET; box_z = BOX_RESET;
        wrap_mask = MASK_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset boxes: integer offsets wrap to zero
        rows.insert(rows.size(), '{'{32'h0003_0000, 0, 0, 0, 0, 0}, 1, zero});
        rows.insert(rows.size(), '{'{0, 0, 0, 0, 0, 0}, 1, zero});
        rows.insert(rows.size(), '{'{32'h0000_8000, 0, 0, 0, 0, 0}, 1, 33'h0_8000});
        rows.insert(rows.size(), '{'{32'h0000_4000, 32'h0000_4000, 0, 0, 0, 0}, 0, zero});
        rows.insert(rows.size(), '{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0, zero});
        rows.insert(rows.size(), '{'{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                           32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001}, 0, zero});
        foreach (rows[i])
            send(rows[i].p, rows[i].known, rows[i].want_dist, i != rows.size() - 1);
        drain();
        // open box: raw differences, worst-case sum
        write_reg(CFG_MASK, 31'd0);
        rows.delete();
        rows.insert(rows.size(), '{'{32'h0003_0000, 0, 0, 0, 0, 0}, 1, 33'h3_0000});
        rows.insert(rows.size(), '{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0, zero});
        rows.insert(rows.size(), '{'{32'h8000_0000, 0, 32'h7fff_ffff,
                           32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000}, 0, zero});
        rows.insert(rows.size(), '{'{0, 32'h0004_0000, 0, 0, 0, 32'h0003_0000}, 1, 33'h5_0000});
        foreach (rows[i])
            send(rows[i].p, rows[i].known, rows[i].want_dist, i != rows.size() - 1);
        drain();
        // zero box with wrap on, max box
        write_reg(CFG_MASK, 31'd7);
        write_reg(CFG_BOX_X, 31'd0);
        write_reg(CFG_BOX_Y, 31'd3);
        write_reg(CFG_BOX_Z, 31'h7fff_ffff);
        rows.delete();
        rows.insert(rows.size(), '{'{32'h0001_0000, 0, 0, 0, 0, 0}, 1, 33'h1_0000});
        rows.insert(rows.size(), '{'{0, 32'h0000_0003, 0, 0, 0, 0}, 0, zero});
        rows.insert(rows.size(), '{'{0, 32'hffff_fffe, 0, 0, 32'h0000_0001, 0}, 0, zero});
        rows.insert(rows.size(), '{'{0, 0, 32'h7fff_ffff, 0, 0, 32'h8000_0000}, 0, zero});
        rows.insert(rows.size(), '{'{0, 0, 32'h3fff_ffff, 0, 0, 32'hc000_0000}, 0, zero});
        foreach (rows[i])
            send(rows[i].p, rows[i].known, rows[i].want_dist, i != rows.size() - 1);
        drain();

        // random phases with fresh register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_BOX_X, rnd_box());
            write_reg(CFG_BOX_Y, rnd_box());
            write_reg(CFG_BOX_Z, rnd_box());
            write_reg(CFG_MASK, 31'($urandom_range(0, 7)));
            for (int k = 0; k < 75; k += burst)
            begin
                burst = $urandom_range(1, 12);
                // long receiver hold while the sender keeps offering
                if (ph == 2 && k == 0)
                    hold_req = 1;
                for (int j = 0; j < burst; j++)
                begin
                    p = {rnd_coord(), rnd_coord(), rnd_coord(),
                         rnd_coord(), rnd_coord(), rnd_coord()};
                    send(p, 0, zero, j != burst - 1);
                end
                if ($urandom_range(0, 9) == 0)
                    drain();
                else
                    repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            drain();
        end

        $display("Ran %0d pairs over directed and 8 random box/mask settings; %0d checked.",
                 n_sent, n_seen);
        if (errors == 0 && dist_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

`default_nettype wire

### periodic_min_image_distance_core.f
hdl/pmid_pkg.sv
hdl/pmid_mod_cell.sv
hdl/pmid_sqrt_cell.sv
hdl/pmid_axis.sv
hdl/periodic_min_image_distance_core.sv
hdl/pmid_checker.sv
sim/tb_top.sv
